/* src/efr_pkg.sv */
package efr_pkg;

  // framing and escape codes
  localparam logic [7:0] START_BYTE = 8'h98;
  localparam logic [7:0] END_BYTE   = 8'h9C;
  localparam logic [7:0] ESC_BYTE   = 8'h91;
  localparam logic [7:0] ESC_END    = 8'h63;
  localparam logic [7:0] ESC_START  = 8'h67;
  localparam logic [7:0] ESC_ESC    = 8'h6E;

  // message kinds sent by the control panel
  localparam logic [7:0] KIND_PANEL_A = 8'h07;
  localparam logic [7:0] KIND_PANEL_B = 8'h09;

  // config register reset values
  localparam logic [15:0] POLY_RST = 16'h90D9;
  localparam logic [15:0] INIT_RST = 16'hFFFF;

  // counter limits and frame length thresholds
  localparam logic [7:0] CNT_MAX     = 8'd255;
  localparam logic [7:0] MIN_RAW     = 8'd6;
  localparam logic [7:0] MIN_DECODED = 8'd10;
  localparam int         HDR_BYTES   = 8;

  // config register indexes
  localparam logic CFG_POLY = 1'b0;
  localparam logic CFG_INIT = 1'b1;

  // frame status codes
  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_SHORT   = 2'd2;

  typedef struct packed {
    logic [15:0] poly;
    logic [15:0] init;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [7:0]  station_address;
    logic [7:0]  message_kind;
    logic [15:0] message_code;
    logic [31:0] payload_word;
    logic        from_panel;
    logic [7:0]  decoded_length;
  } res_t;

  // one byte through an msb-first crc16, no reflection
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* src/efr_if.sv */
interface efr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface efr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [7:0]  station_address;
  logic [7:0]  message_kind;
  logic [15:0] message_code;
  logic [31:0] payload_word;
  logic        from_panel;
  logic [7:0]  decoded_length;

  modport source (output valid, output frame_status, output station_address,
                  output message_kind, output message_code, output payload_word,
                  output from_panel, output decoded_length, input ready);
  modport sink (input valid, input frame_status, input station_address,
                input message_kind, input message_code, input payload_word,
                input from_panel, input decoded_length, output ready);
endinterface

interface efr_cfg_if;
  logic        valid;
  logic        ready;
  logic        reg_index;
  logic [15:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

/* src/efr_cfg_regs.sv */
module efr_cfg_regs
  import efr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_valid,
  output logic        wr_ready,
  input  logic        wr_index,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  logic [15:0] poly_r;
  logic [15:0] init_r;

  // registers are always writable
  assign wr_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= POLY_RST;
      init_r <= INIT_RST;
    end else if (wr_valid) begin
      case (wr_index)
        CFG_POLY: poly_r <= wr_data;
        CFG_INIT: init_r <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg.poly = poly_r;
  assign cfg.init = init_r;

endmodule

/* src/efr_deframer.sv */
module efr_deframer
  import efr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       adv,
  output logic       res_valid,
  output res_t       res
);

  // input register
  logic       inv_r, inv_nxt;
  logic [7:0] byte_r;

  // frame state
  logic        in_frame_r, in_frame_nxt;
  logic        esc_r, esc_nxt;
  logic [7:0]  raw_r, raw_nxt;
  logic [7:0]  dcnt_r, dcnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] tail_r, tail_nxt;
  logic        pend_vld_r, pend_vld_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [7:0]  hdr_r [HDR_BYTES];
  logic [7:0]  hdr_nxt [HDR_BYTES];

  logic        proc;
  logic        two;
  logic [7:0]  d0, d1;
  logic        out0_vld, out1_vld;
  logic [7:0]  feed_byte;
  logic [15:0] feed_crc;
  logic [15:0] final_crc;
  logic [8:0]  dsum;
  logic        fire;

  assign in_ready = !inv_r || adv;
  assign proc     = inv_r && adv;

  // input register
  always_comb begin
    inv_nxt = inv_r;
    if (in_valid && in_ready) begin
      inv_nxt = 1'b1;
    end else if (adv) begin
      inv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else begin
      inv_r <= inv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= rx_byte;
    end
  end

  // escape decode: one or two decoded bytes
  always_comb begin
    two = 1'b0;
    d0  = byte_r;
    d1  = byte_r;
    if (esc_r) begin
      case (byte_r)
        ESC_END:   d0 = END_BYTE;
        ESC_START: d0 = START_BYTE;
        ESC_ESC:   d0 = ESC_BYTE;
        default: begin
          d0  = ESC_BYTE;
          two = 1'b1;
        end
      endcase
    end
  end

  // bytes that leave the checksum window
  assign out0_vld = (dcnt_r >= 8'd2);
  assign out1_vld = two && (dcnt_r >= 8'd1);

  // shared crc byte update, fed from the pending byte first
  always_comb begin
    if (pend_vld_r) begin
      feed_byte = pend_r;
    end else if (out0_vld) begin
      feed_byte = tail_r[15:8];
    end else begin
      feed_byte = tail_r[7:0];
    end
  end

  assign feed_crc  = crc_feed(crc_r, feed_byte, cfg.poly);
  assign final_crc = pend_vld_r ? feed_crc : crc_r;
  assign dsum      = {1'b0, dcnt_r} + (two ? 9'd2 : 9'd1);
  assign fire      = proc && (byte_r == END_BYTE) && in_frame_r && (raw_r >= MIN_RAW);

  // frame state update
  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    raw_nxt      = raw_r;
    dcnt_nxt     = dcnt_r;
    crc_nxt      = crc_r;
    tail_nxt     = tail_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    for (int k = 0; k < HDR_BYTES; k++) begin
      hdr_nxt[k] = hdr_r[k];
    end

    if (proc && (byte_r == START_BYTE || byte_r == END_BYTE)) begin
      // open or close: clear the frame
      in_frame_nxt = (byte_r == START_BYTE);
      esc_nxt      = 1'b0;
      raw_nxt      = (byte_r == START_BYTE) ? 8'd1 : 8'd0;
      dcnt_nxt     = 8'd0;
      crc_nxt      = cfg.init;
      tail_nxt     = 16'h0000;
      pend_vld_nxt = 1'b0;
      for (int k = 0; k < HDR_BYTES; k++) begin
        hdr_nxt[k] = 8'h00;
      end
    end else if (proc && in_frame_r) begin
      if (raw_r != CNT_MAX) begin
        raw_nxt = raw_r + 8'd1;
      end
      if (byte_r == ESC_BYTE) begin
        // escape takes no decoded byte: spend the cycle on the pending byte
        esc_nxt = 1'b1;
        if (pend_vld_r) begin
          crc_nxt      = feed_crc;
          pend_vld_nxt = 1'b0;
        end
      end else begin
        esc_nxt = 1'b0;
        // one crc update a byte, the leftover is held as the pending byte
        if (pend_vld_r || out0_vld || out1_vld) begin
          crc_nxt = feed_crc;
        end
        if (pend_vld_r) begin
          pend_vld_nxt = out0_vld;
          pend_nxt     = tail_r[15:8];
        end else begin
          pend_vld_nxt = out0_vld && out1_vld;
          pend_nxt     = tail_r[7:0];
        end
        tail_nxt = two ? {d0, d1} : {tail_r[7:0], d0};
        dcnt_nxt = (dsum > {1'b0, CNT_MAX}) ? CNT_MAX : dsum[7:0];
        for (int k = 0; k < HDR_BYTES; k++) begin
          if ({1'b0, dcnt_r} == 9'(k)) begin
            hdr_nxt[k] = d0;
          end else if (two && ({1'b0, dcnt_r} + 9'd1 == 9'(k))) begin
            hdr_nxt[k] = d1;
          end
        end
      end
    end else if (!proc && pend_vld_r) begin
      // idle cycle drains the pending byte
      crc_nxt      = feed_crc;
      pend_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      raw_r      <= 8'd0;
      dcnt_r     <= 8'd0;
      crc_r      <= INIT_RST;
      tail_r     <= 16'h0000;
      pend_vld_r <= 1'b0;
      for (int k = 0; k < HDR_BYTES; k++) begin
        hdr_r[k] <= 8'h00;
      end
    end else begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      raw_r      <= raw_nxt;
      dcnt_r     <= dcnt_nxt;
      crc_r      <= crc_nxt;
      tail_r     <= tail_nxt;
      pend_vld_r <= pend_vld_nxt;
      for (int k = 0; k < HDR_BYTES; k++) begin
        hdr_r[k] <= hdr_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  // result of a closed frame
  always_comb begin
    res_valid           = fire;
    res.station_address = hdr_r[0];
    res.message_kind    = hdr_r[1];
    res.message_code    = {hdr_r[2], hdr_r[3]};
    res.payload_word    = {hdr_r[4], hdr_r[5], hdr_r[6], hdr_r[7]};
    res.from_panel      = hdr_r[1] inside {KIND_PANEL_A, KIND_PANEL_B};
    res.decoded_length  = dcnt_r;
    if (dcnt_r < MIN_DECODED) begin
      res.frame_status = ST_SHORT;
    end else if (final_crc == tail_r) begin
      res.frame_status = ST_GOOD;
    end else begin
      res.frame_status = ST_CRC_ERR;
    end
  end

endmodule

/* src/efr_out_reg.sv */
module efr_out_reg
  import efr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res,
  output logic adv,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic vld_r, vld_nxt;
  res_t res_r;

  // the slot is free when empty or being taken this cycle
  assign adv = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

/* src/escaped_frame_receiver_crc16.sv */
// channel   dir  handshake          payload
// in_ch     in   valid/ready        rx_byte[7:0]
// out_ch    out  valid/ready        frame_status, header fields, from_panel, decoded_length
// cfg_ch    in   valid/ready (=1)   reg_index (0 polynomial, 1 initial), wr_data[15:0]
//
// one byte per cycle while in_ch.ready is high; a frame result passes the input register,
// then the result register, after its end byte is accepted
// rst_n is synchronous: frame state clears, polynomial 0x90d9 and initial 0xffff reload
// in_ch.ready drops only while the input register is full and an untaken result blocks it
module escaped_frame_receiver_crc16
  import efr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  efr_in_if.sink           in_ch,
  efr_out_if.source        out_ch,
  efr_cfg_if.sink          cfg_ch
);

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic res_valid;
  logic adv;

  // configuration registers
  efr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_ready (cfg_ch.ready),
    .wr_index (cfg_ch.reg_index),
    .wr_data  (cfg_ch.wr_data),
    .cfg      (cfg)
  );

  // deframing, unescape and crc
  efr_deframer u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .rx_byte   (in_ch.rx_byte),
    .adv       (adv),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  efr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .adv       (adv),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.frame_status    = out_res.frame_status;
  assign out_ch.station_address = out_res.station_address;
  assign out_ch.message_kind    = out_res.message_kind;
  assign out_ch.message_code    = out_res.message_code;
  assign out_ch.payload_word    = out_res.payload_word;
  assign out_ch.from_panel      = out_res.from_panel;
  assign out_ch.decoded_length  = out_res.decoded_length;

endmodule

/* src/efr_checker.sv */
module efr_checker
  import efr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] frame_status,
  input logic [7:0] message_kind,
  input logic       from_panel,
  input logic [7:0] decoded_length
);

  // an offered result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (frame_status == ST_GOOD || frame_status == ST_CRC_ERR ||
                   frame_status == ST_SHORT))
    else $error("undefined frame status");

  // short status exactly for frames under the minimum decoded length
  a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((frame_status == ST_SHORT) == (decoded_length < MIN_DECODED)))
    else $error("short status disagrees with decoded length");

  // panel flag follows the message kind
  a_panel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (from_panel == (message_kind == KIND_PANEL_A ||
                                  message_kind == KIND_PANEL_B)))
    else $error("panel flag disagrees with message kind");

endmodule

bind escaped_frame_receiver_crc16 efr_checker u_efr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .frame_status   (out_ch.frame_status),
  .message_kind   (out_ch.message_kind),
  .from_panel     (out_ch.from_panel),
  .decoded_length (out_ch.decoded_length)
);

/* tb/efr_checker.sv */
module efr_scoreboard
  import efr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  res_t        out_frame,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_reg_index,
  input  logic [15:0] cfg_wr_data,
  output int unsigned frames_due,
  output int unsigned fail_count
);

  // shadow copy of the registers and the deframer state
  logic [15:0] poly_reg;
  logic [15:0] init_reg;
  logic        framing;
  logic        esc_held;
  logic [7:0]  raw_cnt;
  logic [7:0]  dec_cnt;
  logic [15:0] crc_acc;
  logic [15:0] last_two;
  logic [63:0] head;
  res_t        frames_q[$];
  int unsigned errs = 0;

  // msb-first crc16 over one byte
  function automatic logic [15:0] crc_advance(logic [15:0] acc, logic [7:0] b,
                                              logic [15:0] gen);
    logic [15:0] r;
    r = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ gen) : (r << 1);
    end
    return r;
  endfunction

  // per-frame state back to empty
  task automatic restart_frame();
    esc_held = 1'b0;
    raw_cnt  = '0;
    dec_cnt  = '0;
    crc_acc  = init_reg;
    last_two = '0;
    head     = '0;
  endtask

  // one decoded byte: the byte two back enters the crc, the last two stay aside
  task automatic take_byte(logic [7:0] b);
    int slot;
    slot = 7 - int'(dec_cnt);
    if (dec_cnt >= 8'd2) begin
      crc_acc = crc_advance(crc_acc, last_two[15:8], poly_reg);
    end
    last_two = {last_two[7:0], b};
    if (int'(dec_cnt) < HDR_BYTES) begin
      head[8*slot +: 8] = b;
    end
    if (dec_cnt < CNT_MAX) begin
      dec_cnt++;
    end
  endtask

  // end byte: report an open frame unless it is too small to count
  task automatic close_frame();
    res_t r;
    if (framing && raw_cnt >= MIN_RAW) begin
      if (dec_cnt < MIN_DECODED) begin
        r.frame_status = ST_SHORT;
      end else if (crc_acc == last_two) begin
        r.frame_status = ST_GOOD;
      end else begin
        r.frame_status = ST_CRC_ERR;
      end
      r.station_address = head[63:56];
      r.message_kind    = head[55:48];
      r.message_code    = head[47:32];
      r.payload_word    = head[31:0];
      r.from_panel      = (head[55:48] == KIND_PANEL_A) || (head[55:48] == KIND_PANEL_B);
      r.decoded_length  = dec_cnt;
      frames_q = {frames_q, r};
    end
    framing = 1'b0;
    restart_frame();
  endtask

  // one raw byte from the line
  task automatic accept_byte(logic [7:0] b);
    if (b == START_BYTE) begin
      framing = 1'b1;
      restart_frame();
      raw_cnt = 8'd1;
    end else if (b == END_BYTE) begin
      close_frame();
    end else if (framing) begin
      if (raw_cnt < CNT_MAX) begin
        raw_cnt++;
      end
      if (b == ESC_BYTE) begin
        esc_held = 1'b1;
      end else if (esc_held) begin
        esc_held = 1'b0;
        case (b)
          ESC_END:   take_byte(END_BYTE);
          ESC_START: take_byte(START_BYTE);
          ESC_ESC:   take_byte(ESC_BYTE);
          default: begin
            take_byte(ESC_BYTE);
            take_byte(b);
          end
        endcase
      end else begin
        take_byte(b);
      end
    end
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s expected 0x%0h got 0x%0h", field, want, got);
      errs++;
    end
  endtask

  // compare one result against the oldest frame waiting
  task automatic compare_frame(res_t got);
    res_t want;
    if (frames_q.size() == 0) begin
      $error("frame result with none expected: status %0d length %0d",
             got.frame_status, got.decoded_length);
      errs++;
    end else begin
      want = frames_q.pop_front();
      check_field("frame_status", 32'(want.frame_status), 32'(got.frame_status));
      check_field("station_address", 32'(want.station_address), 32'(got.station_address));
      check_field("message_kind", 32'(want.message_kind), 32'(got.message_kind));
      check_field("message_code", 32'(want.message_code), 32'(got.message_code));
      check_field("payload_word", want.payload_word, got.payload_word);
      check_field("from_panel", 32'(want.from_panel), 32'(got.from_panel));
      check_field("decoded_length", 32'(want.decoded_length), 32'(got.decoded_length));
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      poly_reg = POLY_RST;
      init_reg = INIT_RST;
      framing  = 1'b0;
      restart_frame();
      frames_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        compare_frame(out_frame);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_reg_index == CFG_POLY) begin
          poly_reg = cfg_wr_data;
        end else begin
          init_reg = cfg_wr_data;
        end
      end
      if (in_valid && in_ready) begin
        accept_byte(in_rx_byte);
      end
    end
    frames_due <= frames_q.size();
    fail_count <= errs;
  end

endmodule

/* tb/tb_escaped_frame_receiver_crc16.sv */
module tb_escaped_frame_receiver_crc16;
  import efr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        hold_request = 1'b0;
  logic        burst_mode = 1'b0;
  logic [15:0] cur_poly = POLY_RST;
  logic [15:0] cur_init = INIT_RST;
  int unsigned bytes_sent = 0;
  int unsigned frames_due;
  int unsigned fail_count;
  res_t        seen_frame;

  efr_in_if  in_ch();
  efr_out_if out_ch();
  efr_cfg_if cfg_ch();

  escaped_frame_receiver_crc16 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  assign seen_frame = {out_ch.frame_status, out_ch.station_address, out_ch.message_kind,
                       out_ch.message_code, out_ch.payload_word, out_ch.from_panel,
                       out_ch.decoded_length};

  efr_scoreboard chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_rx_byte    (in_ch.rx_byte),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_frame     (seen_frame),
    .cfg_valid     (cfg_ch.valid),
    .cfg_ready     (cfg_ch.ready),
    .cfg_reg_index (cfg_ch.reg_index),
    .cfg_wr_data   (cfg_ch.wr_data),
    .frames_due    (frames_due),
    .fail_count    (fail_count)
  );

  // 20 unit clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(60, 10);
  endfunction

  // msb-first crc16 with the polynomial last written, bit at a time
  function automatic logic [15:0] crc16_next(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      r = (r[15] ^ b[k]) ? ((r << 1) ^ cur_poly) : (r << 1);
    end
    return r;
  endfunction

  // any byte but the start, end and escape bytes
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom);
    end while (b == START_BYTE || b == END_BYTE || b == ESC_BYTE);
    return b;
  endfunction

  // frame content, leaning on codes that need escaping and on panel kinds
  function automatic logic [7:0] pick_byte(int pos);
    int unsigned r;
    r = $urandom_range(15);
    if (pos == 1 && r < 6) begin
      return r[0] ? KIND_PANEL_A : KIND_PANEL_B;
    end
    case (r)
      0: return START_BYTE;
      1: return END_BYTE;
      2: return ESC_BYTE;
      3: return 8'h00;
      4: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) begin
      return $urandom_range(16, 8);
    end else if (r < 85) begin
      return $urandom_range(7, 0);
    end
    return $urandom_range(40, 17);
  endfunction

  // one request on the input channel, after an optional gap
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = burst_mode ? 0 : idle_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_coded(logic [7:0] b);
    case (b)
      START_BYTE: begin
        send_byte(ESC_BYTE);
        send_byte(ESC_START);
      end
      END_BYTE: begin
        send_byte(ESC_BYTE);
        send_byte(ESC_END);
      end
      ESC_BYTE: begin
        send_byte(ESC_BYTE);
        send_byte(ESC_ESC);
      end
      default: send_byte(b);
    endcase
  endtask

  // a framed message with trailing crc, sometimes corrupted or malformed
  task automatic send_frame(int body_len);
    logic [7:0]  body[$];
    logic [15:0] c;
    int unsigned quirk;
    burst_mode = ($urandom_range(5) == 0);
    for (int i = 0; i < body_len; i++) begin
      body = {body, pick_byte(i)};
    end
    c = cur_init;
    foreach (body[i]) begin
      c = crc16_next(c, body[i]);
    end
    if ($urandom_range(4) == 0) begin
      c ^= 16'h0001 << $urandom_range(15);
    end
    body = {body, c[15:8], c[7:0]};
    quirk = $urandom_range(19);
    send_byte(START_BYTE);
    foreach (body[i]) begin
      // doubled escape
      if (quirk == 0 && i == 3) begin
        send_byte(ESC_BYTE);
        send_byte(ESC_BYTE);
        send_byte(ESC_END);
      end
      // unknown escape
      if (quirk == 1 && i == 4) begin
        send_byte(ESC_BYTE);
        send_byte(plain_byte());
      end
      // restart in the middle
      if (quirk == 2 && i == body.size() / 2) begin
        send_byte(START_BYTE);
      end
      send_coded(body[i]);
    end
    // dangling escape
    if (quirk == 3) begin
      send_byte(ESC_BYTE);
    end
    // otherwise closed; one case leaves the frame open
    if (quirk != 4) begin
      send_byte(END_BYTE);
    end
    burst_mode = 1'b0;
  endtask

  // stop offering, wait for every frame to come out and the pipe to settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (frames_due != 0);
    repeat (8) @(posedge clk);
  endtask

  // both registers back to back on the configuration channel
  task automatic write_cfg(logic [15:0] poly, logic [15:0] init);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= CFG_POLY;
    cfg_ch.wr_data   <= poly;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.reg_index <= CFG_INIT;
    cfg_ch.wr_data   <= init;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_poly = poly;
    cur_init = init;
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int unsigned stall;
    int unsigned run;
    logic        hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      run = ($urandom_range(99) < 80) ? $urandom_range(8, 1) : $urandom_range(200, 50);
      out_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = idle_len();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [7:0] opening[$];
    in_ch.valid      <= 1'b0;
    in_ch.rx_byte    <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= CFG_POLY;
    cfg_ch.wr_data   <= '0;
    rst_n            <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // end byte and noise outside a frame; escapes of all kinds in a short frame;
    // a frame of raw length five; a dangling escape at the end byte
    opening = '{END_BYTE, 8'h42,
                START_BYTE, 8'h00, 8'hFF, ESC_BYTE, ESC_END, ESC_BYTE, ESC_START,
                ESC_BYTE, ESC_ESC, ESC_BYTE, ESC_BYTE, 8'h11, END_BYTE,
                START_BYTE, KIND_PANEL_A, KIND_PANEL_B, 8'h55, 8'hAA, END_BYTE,
                START_BYTE, 8'h09, 8'h07, 8'h01, 8'h80, 8'h7F, ESC_BYTE, END_BYTE};
    foreach (opening[i]) begin
      send_byte(opening[i]);
    end
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      // registers change with a frame left open across the writes
      if (phase != 0) begin
        send_byte(START_BYTE);
        repeat (5) send_byte(plain_byte());
        drain();
        case (phase)
          1: write_cfg(16'h0000, 16'h0000);
          2: write_cfg(16'hFFFF, 16'hFFFF);
          3: write_cfg(16'h1021, 16'h1D0F);
          default: write_cfg(16'($urandom), 16'($urandom));
        endcase
        repeat (8) send_byte(plain_byte());
        send_byte(END_BYTE);
      end
      if (phase == 2) begin
        hold_request <= 1'b1;
      end
      // long frames run both counters into saturation
      if (phase == 1 || phase == 3) begin
        send_frame(300);
      end
      while (bytes_sent < (phase + 1) * 230) begin
        if ($urandom_range(99) < 85) begin
          send_frame(pick_len());
        end else begin
          repeat ($urandom_range(4, 1)) send_byte(8'($urandom) == START_BYTE ?
                                                  END_BYTE : 8'($urandom));
        end
      end
    end
    drain();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // give up after a generous fixed time
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
